// File: hdl/audio_peak_rms_meter_defines.svh
// assertion macros for the audio peak and rms meter
// used by the top level only, needs clk_i and rst_ni in scope
`ifndef AUDIO_PEAK_RMS_METER_DEFINES_SVH
`define AUDIO_PEAK_RMS_METER_DEFINES_SVH

// same-cycle implication, quiet while in reset
`define APRM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while in reset
`define APRM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/aprm_pkg.sv
// shared types and constants for the audio peak and rms meter
// no dependencies
package aprm_pkg;

  localparam int unsigned COUNT_BITS  = 20;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned MAG_W       = 16;
  localparam int unsigned SQ_W        = 2 * MAG_W;
  // largest square is 2^30, summed over at most 2^COUNT_BITS - 1 samples
  localparam int unsigned ENERGY_W    = 2 * (MAG_W - 1) + COUNT_BITS;
  // mean square never exceeds 2^30
  localparam int unsigned QUO_W       = 2 * (MAG_W - 1) + 1;
  localparam int unsigned ROOT_W      = QUO_W + 1;
  localparam int unsigned SQRT_STEPS  = (QUO_W + 1) / 2;
  localparam int unsigned ALU_W       = (COUNT_BITS + 1 > ROOT_W) ? COUNT_BITS + 1 : ROOT_W;
  localparam int unsigned STEP_W      = $clog2(ENERGY_W);
  localparam int unsigned OUT_COUNT_W = 20;
  localparam int unsigned LEVEL_W     = 16;

  localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = '1;

  localparam logic [1:0] KIND_SAMPLE  = 2'd0;
  localparam logic [1:0] KIND_CLOSE   = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  typedef struct packed {
    logic [1:0]                 kind;
    logic signed [SAMPLE_W-1:0] sample;
  } aprm_in_t;

  typedef struct packed {
    logic [OUT_COUNT_W-1:0] sample_count;
    logic [LEVEL_W-1:0]     peak_level;
    logic [LEVEL_W-1:0]     rms_level;
    logic                   saturated;
  } aprm_out_t;

  typedef struct packed {
    logic [ALU_W-1:0] diff;
    logic             ge;
  } aprm_alu_res_t;

endpackage

// File: hdl/aprm_alu.sv
// shared subtract and compare unit of the meter
// depends on aprm_pkg
module aprm_alu (
  input  logic [aprm_pkg::ALU_W-1:0] a_i,
  input  logic [aprm_pkg::ALU_W-1:0] b_i,
  output aprm_pkg::aprm_alu_res_t    res_o
);
  import aprm_pkg::*;

  logic [ALU_W:0] diff_full;

  // extra top bit is the borrow
  assign diff_full  = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.diff = diff_full[ALU_W-1:0];
  assign res_o.ge   = ~diff_full[ALU_W];

endmodule

// File: hdl/audio_peak_rms_meter.sv
// Audio peak and rms level meter. A sample beat (kind sample) adds one signed 16-bit
// PCM value to the current window: peak magnitude, sum of squares and sample count.
// A close beat reports count, peak, rms and a saturation flag, then clears the window;
// a restart beat clears it silently, and kind 3 is ignored. Rms is isqrt(energy/count),
// 0 for an empty window. Once the count reaches 2^20 - 1 it and the energy stop growing,
// the peak is still tracked and the report sets saturated. Timing: a sample takes its
// magnitude at accept, then holds the input stall through the square and accumulate
// states before the next beat can go in. A restart or ignored beat does not stall the
// input. A close of an empty window goes straight to the hand-off; any other close runs
// 50 restoring divide steps and 16 square root steps, each one pass through the single
// shared subtractor, between the load and the hand-off to the output register. The
// result sits in an output register, so new beats are accepted while a report waits;
// a second report waits in its final state until the output register is free.
// depends on aprm_pkg, aprm_alu and audio_peak_rms_meter_defines.svh
`include "audio_peak_rms_meter_defines.svh"

module audio_peak_rms_meter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  aprm_pkg::aprm_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output aprm_pkg::aprm_out_t out_data_o
);
  import aprm_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;  // square the magnitude, track the peak
  localparam logic [2:0] ST_ACC  = 3'd2;  // add to energy and count
  localparam logic [2:0] ST_DIV  = 3'd3;  // one quotient bit per cycle
  localparam logic [2:0] ST_SQRT = 3'd4;  // one root bit per cycle
  localparam logic [2:0] ST_FIN  = 3'd5;  // hand result to the output register

  logic [2:0]            state_q, state_d;
  logic [STEP_W-1:0]     cnt_q, cnt_d;

  // window state
  logic [COUNT_BITS-1:0] win_count_q, win_count_d;
  logic [MAG_W-1:0]      win_peak_q, win_peak_d;
  logic [ENERGY_W-1:0]   win_energy_q, win_energy_d;

  // sample path
  logic [MAG_W-1:0]      raw;
  logic [MAG_W-1:0]      mag_q, mag_d;
  logic [SQ_W-1:0]       prod_q, prod_d;

  // report path
  logic [COUNT_BITS-1:0] res_count_q, res_count_d;
  logic [MAG_W-1:0]      res_peak_q, res_peak_d;
  logic                  res_sat_q, res_sat_d;
  logic [ENERGY_W-1:0]   quo_q, quo_d;
  logic [COUNT_BITS-1:0] rem_q, rem_d;
  logic [QUO_W-1:0]      sq_v_q, sq_v_d;
  logic [ROOT_W-1:0]     sq_root_q, sq_root_d;
  logic [QUO_W-1:0]      sq_bit_q, sq_bit_d;

  // output register
  logic                  out_valid_q, out_valid_d;
  aprm_out_t             out_q, out_d;

  // shared unit
  logic [ALU_W-1:0]      alu_a, alu_b;
  aprm_alu_res_t         alu_res;

  logic                  in_accept;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign raw         = in_data_i.sample;

  aprm_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    win_count_d  = win_count_q;
    win_peak_d   = win_peak_q;
    win_energy_d = win_energy_q;
    mag_d        = mag_q;
    prod_d       = prod_q;
    res_count_d  = res_count_q;
    res_peak_d   = res_peak_q;
    res_sat_d    = res_sat_q;
    quo_d        = quo_q;
    rem_d        = rem_q;
    sq_v_d       = sq_v_q;
    sq_root_d    = sq_root_q;
    sq_bit_d     = sq_bit_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    alu_a        = '0;
    alu_b        = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_data_i.kind)
            KIND_SAMPLE: begin
              // -32768 wraps to 0x8000, which reads as 32768 unsigned
              mag_d   = raw[MAG_W-1] ? (~raw + MAG_W'(1)) : raw;
              state_d = ST_SQ;
            end
            KIND_CLOSE: begin
              // snapshot the window, then clear it
              res_count_d  = win_count_q;
              res_peak_d   = win_peak_q;
              res_sat_d    = (win_count_q == COUNT_LIMIT);
              quo_d        = win_energy_q;
              rem_d        = '0;
              sq_root_d    = '0;
              cnt_d        = STEP_W'(ENERGY_W - 1);
              win_count_d  = '0;
              win_peak_d   = '0;
              win_energy_d = '0;
              // empty window reports a zero rms
              state_d      = (win_count_q == '0) ? ST_FIN : ST_DIV;
            end
            KIND_RESTART: begin
              win_count_d  = '0;
              win_peak_d   = '0;
              win_energy_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SQ: begin
        prod_d = SQ_W'(mag_q) * SQ_W'(mag_q);
        if (mag_q > win_peak_q) begin
          win_peak_d = mag_q;
        end
        state_d = ST_ACC;
      end

      ST_ACC: begin
        if (win_count_q != COUNT_LIMIT) begin
          win_energy_d = win_energy_q + ENERGY_W'(prod_q);
          win_count_d  = win_count_q + COUNT_BITS'(1);
        end
        state_d = ST_IDLE;
      end

      ST_DIV: begin
        // restoring divide, quotient bits shift in from the bottom
        alu_a = ALU_W'({rem_q, quo_q[ENERGY_W-1]});
        alu_b = ALU_W'(res_count_q);
        rem_d = alu_res.ge ? COUNT_BITS'(alu_res.diff) : COUNT_BITS'(alu_a);
        quo_d = {quo_q[ENERGY_W-2:0], alu_res.ge};
        if (cnt_q == '0) begin
          // mean square is at most 2^30, the low bits hold all of it
          sq_v_d    = QUO_W'(quo_d);
          sq_root_d = '0;
          sq_bit_d  = {1'b1, {(QUO_W - 1){1'b0}}};
          cnt_d     = STEP_W'(SQRT_STEPS - 1);
          state_d   = ST_SQRT;
        end else begin
          cnt_d = cnt_q - STEP_W'(1);
        end
      end

      ST_SQRT: begin
        // digit-by-digit root, one bit pair per cycle
        alu_a = ALU_W'(sq_v_q);
        alu_b = ALU_W'(sq_root_q + ROOT_W'(sq_bit_q));
        if (alu_res.ge) begin
          sq_v_d    = QUO_W'(alu_res.diff);
          sq_root_d = (sq_root_q >> 1) + ROOT_W'(sq_bit_q);
        end else begin
          sq_root_d = sq_root_q >> 1;
        end
        sq_bit_d = sq_bit_q >> 2;
        if (cnt_q == '0) begin
          state_d = ST_FIN;
        end else begin
          cnt_d = cnt_q - STEP_W'(1);
        end
      end

      ST_FIN: begin
        // wait here while an earlier report is still stalled
        if (!out_valid_q || !out_stall_i) begin
          out_d.sample_count = OUT_COUNT_W'(res_count_q);
          out_d.peak_level   = LEVEL_W'(res_peak_q);
          out_d.rms_level    = LEVEL_W'(sq_root_q);
          out_d.saturated    = res_sat_q;
          out_valid_d        = 1'b1;
          state_d            = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      win_count_q  <= '0;
      win_peak_q   <= '0;
      win_energy_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      win_count_q  <= win_count_d;
      win_peak_q   <= win_peak_d;
      win_energy_q <= win_energy_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    mag_q       <= mag_d;
    prod_q      <= prod_d;
    res_count_q <= res_count_d;
    res_peak_q  <= res_peak_d;
    res_sat_q   <= res_sat_d;
    quo_q       <= quo_d;
    rem_q       <= rem_d;
    sq_v_q      <= sq_v_d;
    sq_root_q   <= sq_root_d;
    sq_bit_q    <= sq_bit_d;
    out_q       <= out_d;
  end

  // a report only appears from the hand-off state
  `APRM_ASSERT_IMP(a_out_from_fin, $rose(out_valid_o), $past(state_q) == ST_FIN, "report without hand-off")
  // divide remainder stays below the divisor
  `APRM_ASSERT_IMP(a_rem_bound, state_q == ST_DIV, rem_q < res_count_q, "remainder out of range")
  // root step bit is a single bit throughout the root
  `APRM_ASSERT_IMP(a_bit_onehot, state_q == ST_SQRT, $onehot(sq_bit_q), "root bit lost")
  // a saturated count does not move on accumulate
  `APRM_ASSERT_NXT(a_sat_hold, (state_q == ST_ACC) && (win_count_q == COUNT_LIMIT), win_count_q == COUNT_LIMIT, "count moved past limit")

endmodule
